// ===== rtl/mlfq_pkg.sv =====
// Shared types and codes of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;

  localparam int unsigned LvlW     = 3;
  localparam int unsigned Levels   = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // Request codes.
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_YIELD  = 3'd1;
  localparam logic [2:0] REQ_ADD    = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_SLEEP  = 3'd4;
  localparam logic [2:0] REQ_START  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_TASK    = 2'd1;
  localparam logic [1:0] ST_NOT_QUEUED = 2'd2;

  // Levels.
  localparam logic [LvlW-1:0] LVL_RT     = 3'd0;
  localparam logic [LvlW-1:0] LVL_HIGH   = 3'd1;
  localparam logic [LvlW-1:0] LVL_NORMAL = 3'd2;
  localparam logic [LvlW-1:0] LVL_LOW    = 3'd3;
  localparam logic [LvlW-1:0] LVL_IDLE   = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_Q_HIGH   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_Q_NORMAL = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_Q_LOW    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_Q_IDLE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BOOST    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_ID  = 3'd5;

  typedef struct packed {
    logic [7:0] q_high;
    logic [7:0] q_normal;
    logic [7:0] q_low;
    logic [7:0] q_idle;
    logic [9:0] boost_int;
    logic [4:0] idle_id;
  } cfg_t;

  typedef struct packed {
    logic [4:0] running_task;
    logic       running_valid;
    logic       switched;
    logic       preempt_request;
    logic [1:0] status;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/mlfq_ram.sv =====
// Single-port-write, registered-read memory used for the per-task tables.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 5,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/mlfq_ctrl.sv =====
// Sequencer of the scheduler: queue registers, running task and table walks.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_ctrl #(
  parameter int unsigned TASKS = 32,
  localparam int unsigned IdW = $clog2(TASKS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             req_type_i,
  input  logic [4:0]             task_id_i,
  input  logic [2:0]             task_priority_i,
  input  mlfq_pkg::cfg_t         cfg_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output mlfq_pkg::res_t         res_o,
  output logic                   nl_we_o,
  output logic [IdW-1:0]         nl_waddr_o,
  output logic [IdW-1:0]         nl_wdata_o,
  output logic [IdW-1:0]         nl_raddr_o,
  input  logic [IdW-1:0]         nl_rdata_i,
  output logic                   lv_we_o,
  output logic [IdW-1:0]         lv_waddr_o,
  output logic [mlfq_pkg::LvlW-1:0] lv_wdata_o,
  output logic [IdW-1:0]         lv_raddr_o,
  input  logic [mlfq_pkg::LvlW-1:0] lv_rdata_i
);
  import mlfq_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TK_LV    = 4'd1;
  localparam logic [3:0] S_YD_LV    = 4'd2;
  localparam logic [3:0] S_AD_LV    = 4'd3;
  localparam logic [3:0] S_RM_LV    = 4'd4;
  localparam logic [3:0] S_RM_STEP  = 4'd5;
  localparam logic [3:0] S_RM_FIN   = 4'd6;
  localparam logic [3:0] S_DQ       = 4'd7;
  localparam logic [3:0] S_DISP     = 4'd8;
  localparam logic [3:0] S_BOOST    = 4'd9;
  localparam logic [3:0] S_BST_STEP = 4'd10;
  localparam logic [3:0] S_BST_LINK = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  localparam logic [IdW-1:0] LastStep = IdW'(TASKS - 1);

  function automatic logic [IdW-1:0] mod_tasks(input logic [4:0] v);
    logic [8:0] r;
    r = {4'b0, v};
    for (int k = 4; k >= 0; k--) begin
      if (32'(r) >= (TASKS << k)) begin
        r = r - 9'(TASKS << k);
      end
    end
    return IdW'(r);
  endfunction

  function automatic logic [LvlW-1:0] lvl_sat(input logic [LvlW-1:0] v);
    return (v > LVL_IDLE) ? LVL_IDLE : v;
  endfunction

  function automatic logic [7:0] quantum_of(input logic [LvlW-1:0] l, input cfg_t c);
    logic [7:0] q;
    case (l)
      LVL_HIGH:   q = c.q_high;
      LVL_NORMAL: q = c.q_normal;
      LVL_LOW:    q = c.q_low;
      LVL_IDLE:   q = c.q_idle;
      default:    q = 8'd0;
    endcase
    return q;
  endfunction

  logic [3:0]      state_q, state_d;
  logic [2:0]      req_q, req_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [LvlW-1:0] prio_q, prio_d;
  logic            prev_on_q, prev_on_d;
  logic [IdW-1:0]  prev_id_q, prev_id_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [IdW-1:0]  head_q [Levels];
  logic [IdW-1:0]  head_d [Levels];
  logic [IdW-1:0]  tail_q [Levels];
  logic [IdW-1:0]  tail_d [Levels];
  logic [Levels-1:0] tv_q, tv_d;
  logic [IdW-1:0]  run_id_q, run_id_d;
  logic            run_on_q, run_on_d;
  logic [7:0]      slice_q, slice_d;
  logic [9:0]      boost_q, boost_d;
  logic [IdW-1:0]  step_q, step_d;
  logic            first_q, first_d;
  logic [IdW-1:0]  pred_q, pred_d;
  logic            has_pred_q, has_pred_d;
  logic [IdW-1:0]  h_q, h_d;
  logic [LvlW-1:0] dq_lvl_q, dq_lvl_d;
  logic            hit_q, hit_d;
  logic            last_q, last_d;
  logic            preempt_q, preempt_d;
  logic [1:0]      status_q, status_d;

  // Enqueue request shared by tick, yield and add.
  logic            enq_en;
  logic [LvlW-1:0] enq_lvl;
  logic [IdW-1:0]  enq_id;

  logic [LvlW-1:0] rd_lvl;
  logic [IdW-1:0]  cur;
  logic [7:0]      slice_dec;
  logic            dq_found;
  logic [LvlW-1:0] dq_sel;

  assign rd_lvl     = lvl_sat(lv_rdata_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    dq_found = 1'b0;
    dq_sel   = LVL_RT;
    for (int q = 0; q < Levels; q++) begin
      if (tv_q[q] && !dq_found) begin
        dq_found = 1'b1;
        dq_sel   = LvlW'(q);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    id_d       = id_q;
    prio_d     = prio_q;
    prev_on_d  = prev_on_q;
    prev_id_d  = prev_id_q;
    lvl_d      = lvl_q;
    head_d     = head_q;
    tail_d     = tail_q;
    tv_d       = tv_q;
    run_id_d   = run_id_q;
    run_on_d   = run_on_q;
    slice_d    = slice_q;
    boost_d    = boost_q;
    step_d     = step_q;
    first_d    = first_q;
    pred_d     = pred_q;
    has_pred_d = has_pred_q;
    h_d        = h_q;
    dq_lvl_d   = dq_lvl_q;
    hit_d      = hit_q;
    last_d     = last_q;
    preempt_d  = preempt_q;
    status_d   = status_q;
    enq_en     = 1'b0;
    enq_lvl    = rd_lvl;
    enq_id     = run_id_q;
    nl_we_o    = 1'b0;
    nl_waddr_o = pred_q;
    nl_wdata_o = nl_rdata_i;
    nl_raddr_o = h_q;
    lv_we_o    = 1'b0;
    lv_waddr_o = id_q;
    lv_wdata_o = prio_q;
    lv_raddr_o = run_id_q;
    res_valid_o = 1'b0;
    cur        = first_q ? head_q[lvl_q] : nl_rdata_i;
    slice_dec  = slice_q - {7'b0, (slice_q != 8'd0)};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d     = req_type_i;
          id_d      = mod_tasks(task_id_i);
          prio_d    = lvl_sat(task_priority_i);
          prev_on_d = run_on_q;
          prev_id_d = run_id_q;
          preempt_d = 1'b0;
          status_d  = ST_OK;
          state_d   = S_DONE;
          case (req_type_i)
            REQ_TICK: begin
              if (run_on_q) begin
                if (boost_q != 10'h3FF) begin
                  boost_d = boost_q + 10'd1;
                end
                state_d = S_TK_LV;
              end
            end
            REQ_YIELD: begin
              if (run_on_q) begin
                state_d = S_YD_LV;
              end
            end
            REQ_ADD:    state_d = S_AD_LV;
            REQ_REMOVE: begin
              lv_raddr_o = mod_tasks(task_id_i);
              state_d    = S_RM_LV;
            end
            REQ_SLEEP: begin
              if (run_on_q) begin
                state_d = S_DQ;
              end
            end
            REQ_START: state_d = S_DQ;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_TK_LV: begin
        lvl_d = rd_lvl;
        if (rd_lvl == LVL_RT) begin
          state_d = S_DONE;
        end else begin
          slice_d = slice_dec;
          if (slice_dec == 8'd0) begin
            enq_en  = 1'b1;
            state_d = S_DQ;
          end else begin
            state_d = S_BOOST;
          end
        end
      end
      S_YD_LV: begin
        enq_en  = 1'b1;
        state_d = S_DQ;
      end
      S_AD_LV: begin
        preempt_d  = run_on_q && (prio_q < rd_lvl);
        lv_we_o    = 1'b1;
        enq_en     = 1'b1;
        enq_lvl    = prio_q;
        enq_id     = id_q;
        state_d    = S_DONE;
      end
      S_RM_LV: begin
        lvl_d = rd_lvl;
        if (!tv_q[rd_lvl]) begin
          status_d = ST_NOT_QUEUED;
          state_d  = S_DONE;
        end else begin
          first_d    = 1'b1;
          has_pred_d = 1'b0;
          step_d     = '0;
          state_d    = S_RM_STEP;
        end
      end
      S_RM_STEP: begin
        // One list entry per cycle; the next link of cur is fetched meanwhile.
        nl_raddr_o = cur;
        first_d    = 1'b0;
        if (cur == id_q) begin
          if (!has_pred_q) begin
            if (cur == tail_q[lvl_q]) begin
              tv_d[lvl_q] = 1'b0;
              state_d     = S_DONE;
            end else begin
              state_d = S_RM_FIN;
            end
          end else if (cur == tail_q[lvl_q]) begin
            tail_d[lvl_q] = pred_q;
            state_d       = S_DONE;
          end else begin
            state_d = S_RM_FIN;
          end
        end else if (cur == tail_q[lvl_q] || step_q == LastStep) begin
          status_d = ST_NOT_QUEUED;
          state_d  = S_DONE;
        end else begin
          pred_d     = cur;
          has_pred_d = 1'b1;
          step_d     = step_q + IdW'(1);
        end
      end
      S_RM_FIN: begin
        if (!has_pred_q) begin
          head_d[lvl_q] = nl_rdata_i;
        end else begin
          nl_we_o = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DQ: begin
        if (dq_found) begin
          h_d        = head_q[dq_sel];
          nl_raddr_o = head_q[dq_sel];
          lv_raddr_o = head_q[dq_sel];
          dq_lvl_d   = dq_sel;
          hit_d      = 1'b1;
          last_d     = (head_q[dq_sel] == tail_q[dq_sel]);
          if (head_q[dq_sel] == tail_q[dq_sel]) begin
            tv_d[dq_sel] = 1'b0;
          end
          state_d = S_DISP;
        end else if (req_q == REQ_SLEEP) begin
          h_d        = mod_tasks(cfg_i.idle_id);
          lv_raddr_o = mod_tasks(cfg_i.idle_id);
          hit_d      = 1'b0;
          state_d    = S_DISP;
        end else begin
          status_d = ST_NO_TASK;
          state_d  = S_DONE;
        end
      end
      S_DISP: begin
        if (hit_q && !last_q) begin
          head_d[dq_lvl_q] = nl_rdata_i;
        end
        run_id_d = h_q;
        run_on_d = 1'b1;
        slice_d  = quantum_of(rd_lvl, cfg_i);
        if (req_q == REQ_TICK && h_q == run_id_q) begin
          state_d = S_BOOST;
        end else begin
          state_d = S_DONE;
        end
      end
      S_BOOST: begin
        state_d = S_DONE;
        if (boost_q >= cfg_i.boost_int) begin
          boost_d = '0;
          if (tv_q[LVL_LOW]) begin
            first_d = 1'b1;
            step_d  = '0;
            state_d = S_BST_STEP;
          end
        end
      end
      S_BST_STEP: begin
        // Relabel each task of the low queue, following the links.
        cur        = first_q ? head_q[LVL_LOW] : nl_rdata_i;
        first_d    = 1'b0;
        lv_we_o    = 1'b1;
        lv_waddr_o = cur;
        lv_wdata_o = LVL_NORMAL;
        nl_raddr_o = cur;
        if (cur == tail_q[LVL_LOW] || step_q == LastStep) begin
          state_d = S_BST_LINK;
        end else begin
          step_d = step_q + IdW'(1);
        end
      end
      S_BST_LINK: begin
        if (tv_q[LVL_NORMAL]) begin
          nl_we_o    = 1'b1;
          nl_waddr_o = tail_q[LVL_NORMAL];
          nl_wdata_o = head_q[LVL_LOW];
        end else begin
          head_d[LVL_NORMAL] = head_q[LVL_LOW];
        end
        tail_d[LVL_NORMAL] = tail_q[LVL_LOW];
        tv_d[LVL_NORMAL]   = 1'b1;
        tv_d[LVL_LOW]      = 1'b0;
        state_d            = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (enq_en) begin
      if (tv_q[enq_lvl]) begin
        nl_we_o    = 1'b1;
        nl_waddr_o = tail_q[enq_lvl];
        nl_wdata_o = enq_id;
      end else begin
        head_d[enq_lvl] = enq_id;
      end
      tail_d[enq_lvl] = enq_id;
      tv_d[enq_lvl]   = 1'b1;
    end
  end

  always_comb begin
    logic [31:0] wide_id;
    wide_id                = 32'(run_id_q);
    res_o.running_task     = wide_id[4:0];
    res_o.running_valid    = run_on_q;
    res_o.switched         = run_on_q && (!prev_on_q || run_id_q != prev_id_q);
    res_o.preempt_request  = preempt_q;
    res_o.status           = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tv_q       <= '0;
      run_id_q   <= '0;
      run_on_q   <= 1'b0;
      slice_q    <= '0;
      boost_q    <= '0;
      prev_on_q  <= 1'b0;
      prev_id_q  <= '0;
      preempt_q  <= 1'b0;
      status_q   <= ST_OK;
      first_q    <= 1'b0;
      has_pred_q <= 1'b0;
      hit_q      <= 1'b0;
      last_q     <= 1'b0;
      step_q     <= '0;
      for (int q = 0; q < Levels; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
      end
    end else begin
      state_q    <= state_d;
      tv_q       <= tv_d;
      run_id_q   <= run_id_d;
      run_on_q   <= run_on_d;
      slice_q    <= slice_d;
      boost_q    <= boost_d;
      prev_on_q  <= prev_on_d;
      prev_id_q  <= prev_id_d;
      preempt_q  <= preempt_d;
      status_q   <= status_d;
      first_q    <= first_d;
      has_pred_q <= has_pred_d;
      hit_q      <= hit_d;
      last_q     <= last_d;
      step_q     <= step_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    id_q     <= id_d;
    prio_q   <= prio_d;
    lvl_q    <= lvl_d;
    pred_q   <= pred_d;
    h_q      <= h_d;
    dq_lvl_q <= dq_lvl_d;
  end

endmodule
`default_nettype wire

// ===== rtl/mlfq_task_scheduler.sv =====
// Top level of the multilevel feedback queue task scheduler.
// Events (tick, yield, add, remove, sleep, start) arrive as words on the
// in_* channel; each event returns exactly one result word on the out_*
// channel: running task, its valid flag, a switch flag, a preemption hint
// for adds and a status code. Quantum, boost interval and idle task are
// written through the cfg_* channel, which is always ready.
// The per-task link and level tables sit in two synchronous memories; a
// sequencer reads, updates and writes them back. A remove walks its queue at
// one entry per cycle and a boost relabels the low queue at one task per
// cycle. A new event is taken once the previous result sits in the output
// register. If the receiver stalls, one result waits there and the block
// still finishes the next event, then holds.
// Reset empties all queues, clears the running task and loads the default
// configuration; the tables need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_task_scheduler #(
  parameter int unsigned TASKS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] req_type_i,
  input  logic [4:0] task_id_i,
  input  logic [2:0] task_priority_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] running_task_o,
  output logic       running_valid_o,
  output logic       switched_o,
  output logic       preempt_request_o,
  output logic [1:0] status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [mlfq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mlfq_pkg::CfgDataW-1:0] cfg_data_i
);
  import mlfq_pkg::*;

  localparam int unsigned IdW = $clog2(TASKS);

  cfg_t cfg_q;
  res_t res, out_q;
  logic out_valid_q;
  logic res_valid, res_ready;

  logic            nl_we, lv_we;
  logic [IdW-1:0]  nl_waddr, nl_wdata, nl_raddr, nl_rdata;
  logic [IdW-1:0]  lv_waddr, lv_raddr;
  logic [LvlW-1:0] lv_wdata, lv_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.q_high    <= 8'd4;
      cfg_q.q_normal  <= 8'd8;
      cfg_q.q_low     <= 8'd16;
      cfg_q.q_idle    <= 8'd32;
      cfg_q.boost_int <= 10'd200;
      cfg_q.idle_id   <= 5'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_Q_HIGH:   cfg_q.q_high    <= cfg_data_i[7:0];
        CFG_Q_NORMAL: cfg_q.q_normal  <= cfg_data_i[7:0];
        CFG_Q_LOW:    cfg_q.q_low     <= cfg_data_i[7:0];
        CFG_Q_IDLE:   cfg_q.q_idle    <= cfg_data_i[7:0];
        CFG_BOOST:    cfg_q.boost_int <= cfg_data_i;
        CFG_IDLE_ID:  cfg_q.idle_id   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  mlfq_ram #(.DEPTH(TASKS), .WIDTH(IdW)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nl_we),
    .waddr_i (nl_waddr),
    .wdata_i (nl_wdata),
    .raddr_i (nl_raddr),
    .rdata_o (nl_rdata)
  );

  mlfq_ram #(.DEPTH(TASKS), .WIDTH(LvlW)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lv_we),
    .waddr_i (lv_waddr),
    .wdata_i (lv_wdata),
    .raddr_i (lv_raddr),
    .rdata_o (lv_rdata)
  );

  mlfq_ctrl #(.TASKS(TASKS)) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .task_id_i       (task_id_i),
    .task_priority_i (task_priority_i),
    .cfg_i           (cfg_q),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .nl_we_o         (nl_we),
    .nl_waddr_o      (nl_waddr),
    .nl_wdata_o      (nl_wdata),
    .nl_raddr_o      (nl_raddr),
    .nl_rdata_i      (nl_rdata),
    .lv_we_o         (lv_we),
    .lv_waddr_o      (lv_waddr),
    .lv_wdata_o      (lv_wdata),
    .lv_raddr_o      (lv_raddr),
    .lv_rdata_i      (lv_rdata)
  );

  // Output register: the result word waits here for the receiver.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign running_task_o    = out_q.running_task;
  assign running_valid_o   = out_q.running_valid;
  assign switched_o        = out_q.switched;
  assign preempt_request_o = out_q.preempt_request;
  assign status_o          = out_q.status;

endmodule
`default_nettype wire

// ===== rtl/mlfq_checker.sv =====
// Port-level checks of the scheduler and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [4:0] running_task_o,
  input logic       running_valid_o,
  input logic       switched_o,
  input logic       preempt_request_o,
  input logic [1:0] status_o
);
  import mlfq_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(running_task_o)
      && $stable(status_o) && $stable(switched_o))
    else $error("result word changed while stalled");

  // A switch always reports a running task.
  a_switch_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && switched_o |-> running_valid_o)
    else $error("switch without running task");

  // Failed start or remove leaves the processor alone.
  a_fail_noswitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> !switched_o && !preempt_request_o)
    else $error("failed request changed running task");

  // A preemption hint only comes from an add, which never switches.
  a_preempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && preempt_request_o |-> running_valid_o && !switched_o)
    else $error("preemption hint with switch or no running task");

endmodule

bind mlfq_task_scheduler mlfq_checker u_mlfq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .running_task_o    (running_task_o),
  .running_valid_o   (running_valid_o),
  .switched_o        (switched_o),
  .preempt_request_o (preempt_request_o),
  .status_o          (status_o)
);
`default_nettype wire
